/* design/clns_pkg.sv */
// shared types and constants for the character lcd nibble sequencer
package clns_pkg;

    typedef enum logic [1:0] {
        MODE_UNINIT = 2'd0,
        MODE_INIT   = 2'd1,
        MODE_XFER   = 2'd2,
        MODE_IDLE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HI_LOW     = 3'd1,
        PH_LO_HIGH    = 3'd2,
        PH_LO_LOW     = 3'd3,
        PH_SINGLE_LOW = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_POLL    = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_LOAD    = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_PARTIAL = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        SEQ_WAIT  = 3'd0,
        SEQ_DIV   = 3'd1,
        SEQ_EXEC  = 3'd2,
        SEQ_STORE = 3'd3,
        SEQ_OUT   = 3'd4
    } seq_state_t;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    localparam logic [3:0] REG_ROW_COUNT   = 4'h0;
    localparam logic [3:0] REG_COL_COUNT   = 4'h4;
    localparam logic [3:0] REG_POWER_DELAY = 4'h8;
    localparam logic [3:0] REG_LONG_DELAY  = 4'hC;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    // divider request and answer between sequencer and divider
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [5:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
        logic [5:0] remainder;
    } div_rsp_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        begin
            unique case (row)
                2'd0: base = 8'h00;
                2'd1: base = 8'h40;
                2'd2: base = 8'h14;
                default: base = 8'h54;
            endcase
            return base;
        end
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] sel);
        logic [7:0] b;
        begin
            unique case (sel)
                2'd0: b = 8'h28;
                2'd1: b = 8'h0C;
                2'd2: b = CMD_CLEAR;
                default: b = 8'h06;
            endcase
            return b;
        end
    endfunction

endpackage

/* design/char_lcd_nibble_sequencer_core.sv */
// top level of the character lcd nibble sequencer
// Each transaction yields exactly one result transaction, and the next one is
// accepted only once that result has been taken. Loads, acks, errors, write
// requests and most polls go through accept, decode, execute and result. A
// poll that starts a byte of a write runs a shift-subtract divider to split
// the cell index into row and column. A byte of a full write also reads the
// screen memory. A character of a partial write divides twice to spot a row
// crossing. Registers: row_count at 0x0, column_count at 0x4,
// power_on_delay_ms at 0x8, long_command_delay_ms at 0xC; write only while the
// block is idle. Screen memory is not cleared at reset.
module char_lcd_nibble_sequencer_core #(
    parameter int SCREEN_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_elapsed_ms,
    input  logic [6:0]  s_char_index,
    input  logic [7:0]  s_char_code,
    input  logic [6:0]  s_position,
    input  logic [6:0]  s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pin_write,
    output logic [3:0]  m_pin_nibble,
    output logic        m_pin_rs,
    output logic        m_pin_enable,
    output logic [1:0]  m_request_status,
    output logic        m_ready_res
);
    import clns_pkg::*;

    localparam int AW = $clog2(SCREEN_DEPTH);

    // config registers
    logic [2:0] row_count_reg;
    logic [4:0] col_count_reg;
    logic [7:0] pod_reg, lcd_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= 3'd4;
            col_count_reg <= 5'd20;
            pod_reg       <= 8'd15;
            lcd_reg       <= 8'd2;
        end else if (cfg_wr) begin
            unique case (paddr)
                REG_ROW_COUNT:   row_count_reg <= pwdata[2:0];
                REG_COL_COUNT:   col_count_reg <= pwdata[4:0];
                REG_POWER_DELAY: pod_reg       <= pwdata[7:0];
                REG_LONG_DELAY:  lcd_reg       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_ROW_COUNT:   prdata = {29'd0, row_count_reg};
            REG_COL_COUNT:   prdata = {27'd0, col_count_reg};
            REG_POWER_DELAY: prdata = {24'd0, pod_reg};
            REG_LONG_DELAY:  prdata = {24'd0, lcd_reg};
            default:         prdata = '0;
        endcase
    end

    // controller state
    mode_t      mode_reg, mode_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] init_step_reg, init_step_next;
    logic       ack_seen_reg, ack_seen_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] delay_reg, delay_next;
    logic [7:0] byte_reg, byte_next;
    logic       rs_reg, rs_next;
    logic [3:0] single_reg, single_next;
    logic       wact_reg, wact_next;
    logic       wpart_reg, wpart_next;
    logic [6:0] full_idx_reg, full_idx_next;
    logic [6:0] pstart_reg, pstart_next;
    logic [6:0] plen_reg, plen_next;
    logic [6:0] psent_reg, psent_next;
    logic       ncur_reg, ncur_next;

    // sequencer and captured transaction
    seq_state_t seq_reg, seq_next;
    logic [2:0] kind_reg;
    logic [7:0] el_reg;
    logic [6:0] ci_reg, pos_reg, len_reg;
    logic [7:0] cc_reg;
    logic [7:0] q1_reg;         // quotient of the earlier division
    logic [1:0] dphase_reg, dphase_next;

    // output register
    logic       ov_reg;
    logic       opw_reg, ors_reg, oen_reg, ordy_reg;
    logic [3:0] onib_reg;
    logic [1:0] ost_reg;

    // result of the execute step
    logic       pw, prs, pe;
    logic [3:0] pn;
    logic [1:0] status;
    logic       need_div, need_mem;

    // divider
    div_req_t   dreq;
    div_rsp_t   drsp;
    clns_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // screen memory
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_idx;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [8:0]    mem_idx;
    clns_screen_ram #(.Depth(SCREEN_DEPTH)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(cc_reg),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );
    assign wr_idx = AW'({1'b0, ci_reg});
    assign wr_en = (seq_reg == SEQ_EXEC) && (kind_reg == KIND_LOAD)
                   && ({2'b0, ci_reg} < 9'(SCREEN_DEPTH));

    logic [5:0] divr;
    logic [7:0] tsum;
    logic [7:0] eff_delay;
    logic       poll_live;   // poll starts the next byte of a write
    logic [7:0] step8, total8, ftotal;
    logic [7:0] pos_cur, pos_nxt;

    assign divr  = (col_count_reg == 5'd0) ? 6'd1 : {1'b0, col_count_reg};
    assign step8 = {3'd0, col_count_reg} + 8'd1;
    assign tsum  = 8'(({1'b0, tick_reg} + {1'b0, el_reg}) > 9'd255 ? 9'd255
                      : {1'b0, tick_reg} + {1'b0, el_reg});
    assign eff_delay = (delay_reg > el_reg) ? 8'(delay_reg - el_reg) : 8'd0;
    assign poll_live = ack_seen_reg && eff_delay == 8'd0
                       && mode_reg != MODE_UNINIT && mode_reg != MODE_IDLE
                       && phase_reg == PH_IDLE && mode_reg == MODE_XFER && wact_reg;

    // full write total steps, clipped at 127
    logic [10:0] tot_raw;
    assign tot_raw = 11'({5'd0, row_count_reg} * {3'd0, step8});
    assign total8  = 8'((tot_raw > 11'd127) ? 11'd127 : tot_raw);
    assign ftotal  = total8;
    assign pos_cur = {1'b0, pstart_reg} + {1'b0, psent_reg};
    assign pos_nxt = pos_cur + 8'd1;

    // decide which division and memory read the data step needs
    always_comb begin
        need_div = 1'b0;
        need_mem = 1'b0;
        if (kind_reg == KIND_POLL && poll_live) begin
            if (wpart_reg) begin
                if (psent_reg < plen_reg) begin
                    need_div = 1'b1;
                    need_mem = !ncur_reg;
                end
            end else if ({1'b0, full_idx_reg} < ftotal) begin
                need_div = 1'b1;
                need_mem = 1'b1;
            end
        end
    end

    // division operands per sub-step: partial cursor -> pos_cur, partial data ->
    // current cell then next cell, full -> full_idx / step
    always_comb begin
        dreq.start    = 1'b0;
        dreq.dividend = 8'd0;
        dreq.divisor  = divr;
        dphase_next   = dphase_reg;
        if (seq_reg == SEQ_WAIT && seq_next == SEQ_DIV) begin
            dreq.start = 1'b1;
            dphase_next = 2'd0;
            if (wpart_reg) begin
                dreq.dividend = ncur_reg ? pos_cur : pos_cur;
            end else begin
                dreq.dividend = {1'b0, full_idx_reg};
                dreq.divisor  = step8[5:0];
            end
        end else if (seq_reg == SEQ_DIV && drsp.done && wpart_reg && !ncur_reg
                     && dphase_reg == 2'd0) begin
            dreq.start    = 1'b1;
            dreq.dividend = pos_nxt;
            dphase_next   = 2'd1;
        end
    end

    // memory read address: partial reads cell by count, full by row/column
    always_comb begin
        if (wpart_reg) begin
            mem_idx = {2'd0, psent_reg};
        end else begin
            mem_idx = 9'({1'b0, drsp.quotient} * {3'd0, col_count_reg})
                      + 9'(drsp.remainder) - 9'd1;
        end
        rd_addr = mem_idx[AW-1:0];
    end

    // sequencer next state
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_WAIT: begin
                if (s_valid && s_ready) seq_next = SEQ_DIV;
            end
            SEQ_DIV: begin
                if (!need_div) seq_next = SEQ_EXEC;
                else if (drsp.done && !(wpart_reg && !ncur_reg && dphase_reg == 2'd0))
                    seq_next = need_mem ? SEQ_STORE : SEQ_EXEC;
            end
            SEQ_STORE: seq_next = SEQ_EXEC;
            SEQ_EXEC:  seq_next = SEQ_OUT;
            SEQ_OUT:   seq_next = (!ov_reg || m_ready) ? SEQ_WAIT : SEQ_OUT;
            default:   seq_next = SEQ_WAIT;
        endcase
    end

    // execute step: the item update
    logic       memok;
    logic [7:0] cell_data;
    logic [7:0] addr8;
    logic [9:0] area;
    assign memok     = ({1'b0, mem_idx} < 10'(SCREEN_DEPTH)) && !mem_idx[8];
    assign cell_data = memok ? rd_data : 8'd0;
    assign area      = 10'({7'd0, row_count_reg} * {5'd0, col_count_reg});

    always_comb begin
        mode_next = mode_reg; phase_next = phase_reg; init_step_next = init_step_reg;
        ack_seen_next = ack_seen_reg; tick_next = tick_reg; delay_next = delay_reg;
        byte_next = byte_reg; rs_next = rs_reg; single_next = single_reg;
        wact_next = wact_reg; wpart_next = wpart_reg; full_idx_next = full_idx_reg;
        pstart_next = pstart_reg; plen_next = plen_reg; psent_next = psent_reg;
        ncur_next = ncur_reg;
        pw = 1'b0; pn = 4'd0; prs = 1'b0; pe = 1'b0; status = STATUS_NONE;
        addr8 = 8'd0;
        if (seq_reg == SEQ_EXEC) begin
            unique case (kind_reg)
                KIND_POLL: begin
                    tick_next = tsum;
                    if (ack_seen_reg) begin
                        delay_next = eff_delay;
                        if (eff_delay == 8'd0) begin
                            if (mode_reg == MODE_UNINIT) begin
                                if (tsum >= pod_reg) begin
                                    mode_next = MODE_INIT; init_step_next = 4'd0;
                                    phase_next = PH_IDLE;
                                end
                            end else if (mode_reg != MODE_IDLE) begin
                                unique case (phase_reg)
                                    PH_IDLE: begin
                                        if (mode_reg == MODE_INIT) begin
                                            if (init_step_reg <= 4'd3) begin
                                                single_next = (init_step_reg < 4'd3)
                                                    ? NIB_WAKE : NIB_FOUR_BIT;
                                                pw = 1'b1; pn = single_next; pe = 1'b1;
                                                phase_next = PH_SINGLE_LOW;
                                            end else if (init_step_reg <= 4'd7) begin
                                                byte_next = init_byte(
                                                    2'(init_step_reg - 4'd4));
                                                rs_next = 1'b0;
                                                pw = 1'b1; pn = byte_next[7:4]; pe = 1'b1;
                                                phase_next = PH_HI_LOW;
                                            end else begin
                                                mode_next = MODE_IDLE;
                                            end
                                        end else if (!wact_reg) begin
                                            mode_next = MODE_IDLE;
                                        end else if (wpart_reg) begin
                                            if (psent_reg >= plen_reg) begin
                                                wact_next = 1'b0; mode_next = MODE_IDLE;
                                            end else if (ncur_reg) begin
                                                addr8 = row_base(drsp.quotient[1:0])
                                                        + {2'd0, drsp.remainder};
                                                byte_next = CMD_SET_DDRAM | addr8;
                                                rs_next = 1'b0;
                                                pw = 1'b1; pn = byte_next[7:4]; pe = 1'b1;
                                                phase_next = PH_HI_LOW;
                                                ncur_next = 1'b0;
                                            end else begin
                                                byte_next = cell_data; rs_next = 1'b1;
                                                pw = 1'b1; prs = 1'b1; pn = cell_data[7:4];
                                                pe = 1'b1; phase_next = PH_HI_LOW;
                                                psent_next = psent_reg + 7'd1;
                                                if (psent_next < plen_reg) begin
                                                    if (q1_reg != drsp.quotient)
                                                        ncur_next = 1'b1;
                                                end else begin
                                                    wact_next = 1'b0;
                                                end
                                            end
                                        end else begin
                                            if ({1'b0, full_idx_reg} >= ftotal) begin
                                                wact_next = 1'b0; mode_next = MODE_IDLE;
                                            end else begin
                                                if (drsp.remainder == 6'd0) begin
                                                    byte_next = CMD_SET_DDRAM
                                                        | row_base(drsp.quotient[1:0]);
                                                    rs_next = 1'b0;
                                                end else begin
                                                    byte_next = cell_data; rs_next = 1'b1;
                                                end
                                                pw = 1'b1; pn = byte_next[7:4];
                                                prs = rs_next; pe = 1'b1;
                                                phase_next = PH_HI_LOW;
                                                full_idx_next = full_idx_reg + 7'd1;
                                                if ({1'b0, full_idx_next} >= ftotal)
                                                    wact_next = 1'b0;
                                            end
                                        end
                                    end
                                    PH_HI_LOW: begin
                                        pw = 1'b1; pn = byte_reg[7:4]; prs = rs_reg;
                                        phase_next = PH_LO_HIGH;
                                    end
                                    PH_LO_HIGH: begin
                                        pw = 1'b1; pn = byte_reg[3:0]; prs = rs_reg;
                                        pe = 1'b1; phase_next = PH_LO_LOW;
                                    end
                                    PH_LO_LOW: begin
                                        pw = 1'b1; pn = byte_reg[3:0]; prs = rs_reg;
                                        phase_next = PH_IDLE;
                                        if (mode_reg == MODE_INIT) begin
                                            delay_next = (byte_reg == CMD_CLEAR
                                                || byte_reg == CMD_HOME) ? lcd_reg : 8'd0;
                                            init_step_next = init_step_reg + 4'd1;
                                        end else begin
                                            delay_next = 8'd0;
                                        end
                                    end
                                    PH_SINGLE_LOW: begin
                                        if (mode_reg == MODE_INIT) begin
                                            pw = 1'b1; pn = single_reg;
                                            delay_next = 8'd0;
                                            init_step_next = init_step_reg + 4'd1;
                                        end
                                        phase_next = PH_IDLE;
                                    end
                                    default: phase_next = PH_IDLE;
                                endcase
                                if (pw) ack_seen_next = 1'b0;
                            end
                        end
                    end
                end
                KIND_ACK: ack_seen_next = 1'b1;
                KIND_LOAD: ;
                KIND_FULL, KIND_PARTIAL: begin
                    if (mode_reg == MODE_IDLE && !wact_reg
                        && !(kind_reg == KIND_PARTIAL
                             && ({3'd0, pos_reg} >= area || len_reg == 7'd0
                                 || {3'd0, pos_reg} + {3'd0, len_reg} > area))) begin
                        if (kind_reg == KIND_FULL) begin
                            full_idx_next = 7'd0; wpart_next = 1'b0;
                        end else begin
                            pstart_next = pos_reg; plen_next = len_reg;
                            psent_next = 7'd0; ncur_next = 1'b1; wpart_next = 1'b1;
                        end
                        wact_next = 1'b1; mode_next = MODE_XFER;
                        phase_next = PH_IDLE; delay_next = 8'd0;
                        status = STATUS_ACCEPTED;
                    end else begin
                        status = STATUS_REJECTED;
                    end
                end
                KIND_ERROR: begin
                    mode_next = MODE_IDLE; phase_next = PH_IDLE; ack_seen_next = 1'b0;
                    wact_next = 1'b0; wpart_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign s_ready = (seq_reg == SEQ_WAIT);

    // sequencer, capture and state registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind; el_reg <= s_elapsed_ms; ci_reg <= s_char_index;
            cc_reg <= s_char_code; pos_reg <= s_position; len_reg <= s_length;
        end
        if (seq_reg == SEQ_DIV && drsp.done && dphase_reg == 2'd0) begin
            q1_reg <= drsp.quotient;
        end
        if (seq_reg == SEQ_EXEC) begin
            opw_reg <= pw; onib_reg <= pn; ors_reg <= prs; oen_reg <= pe;
            ost_reg <= status;
            ordy_reg <= (mode_next == MODE_IDLE) && !wact_next;
        end
        if (!aresetn) begin
            seq_reg <= SEQ_WAIT; ov_reg <= 1'b0; dphase_reg <= 2'd0;
            mode_reg <= MODE_UNINIT; phase_reg <= PH_IDLE; init_step_reg <= '0;
            ack_seen_reg <= 1'b1; tick_reg <= '0; delay_reg <= '0;
            byte_reg <= '0; rs_reg <= 1'b0; single_reg <= '0;
            wact_reg <= 1'b0; wpart_reg <= 1'b0; full_idx_reg <= '0;
            pstart_reg <= '0; plen_reg <= '0; psent_reg <= '0; ncur_reg <= 1'b0;
        end else begin
            seq_reg <= seq_next; dphase_reg <= dphase_next;
            if (seq_reg == SEQ_EXEC) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            mode_reg <= mode_next; phase_reg <= phase_next;
            init_step_reg <= init_step_next; ack_seen_reg <= ack_seen_next;
            tick_reg <= tick_next; delay_reg <= delay_next;
            byte_reg <= byte_next; rs_reg <= rs_next; single_reg <= single_next;
            wact_reg <= wact_next; wpart_reg <= wpart_next;
            full_idx_reg <= full_idx_next; pstart_reg <= pstart_next;
            plen_reg <= plen_next; psent_reg <= psent_next; ncur_reg <= ncur_next;
        end
    end

    assign m_valid          = ov_reg;
    assign m_pin_write      = opw_reg;
    assign m_pin_nibble     = onib_reg;
    assign m_pin_rs         = ors_reg;
    assign m_pin_enable     = oen_reg;
    assign m_request_status = ost_reg;
    assign m_ready_res      = ordy_reg;

    // an issued update always clears the acknowledge flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == SEQ_EXEC && pw) |=> !ack_seen_reg)
        else $error("pin update without ack clear");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == SEQ_EXEC && !pw) |=> (!opw_reg && onib_reg == 4'd0))
        else $error("idle result carries pin data");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wact_reg |-> mode_reg == MODE_XFER)
        else $error("write active outside transfer mode");

endmodule

/* design/clns_divider.sv */
// restoring divider, one quotient bit per cycle
module clns_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  clns_pkg::div_req_t  req,
    output clns_pkg::div_rsp_t  rsp
);
    import clns_pkg::*;

    logic [7:0] quo_reg, quo_next;
    logic [5:0] rem_reg, rem_next;
    logic [5:0] dsr_reg, dsr_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [6:0] trial;

    // one shift-subtract step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[7]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 4'd8;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = 6'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[6:0], 1'b1};
            end else begin
                rem_next = trial[5:0];
                quo_next = {quo_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // a result only appears after a started division
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 4'd0)
        else $error("divider count underflow");

endmodule

/* design/clns_screen_ram.sv */
// character store, one write and one registered read per cycle
module clns_screen_ram #(
    parameter int Depth = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    logic [7:0] mem [Depth];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* dv/char_lcd_nibble_sequencer_core_tb.sv */
// testbench for the character lcd nibble sequencer core, self-checking against a built-in predictor
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core_tb;
    import clns_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] elapsed;
        logic [6:0] idx;
        logic [7:0] code;
        logic [6:0] pos;
        logic [6:0] len;
    } lcd_req_t;

    typedef struct {
        logic       pw;
        logic [3:0] nib;
        logic       rs;
        logic       en;
        logic [1:0] status;
        logic       rdy;
    } pin_result_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_kind = '0;
    logic [7:0]  s_elapsed_ms = '0;
    logic [6:0]  s_char_index = '0;
    logic [7:0]  s_char_code = '0;
    logic [6:0]  s_position = '0;
    logic [6:0]  s_length = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_pin_write;
    logic [3:0]  m_pin_nibble;
    logic        m_pin_rs;
    logic        m_pin_enable;
    logic [1:0]  m_request_status;
    logic        m_ready_res;

    char_lcd_nibble_sequencer_core dut (.*);

    lcd_req_t    pending_reqs[$];
    pin_result_t expected_pins[$];
    logic        hold_off = 1;
    bit          failed = 0;
    int          idle_cycles = 0;

    // clock and reset
    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
    end

    // predictor state
    logic [2:0] cfg_rows = 4;
    logic [4:0] cfg_cols = 20;
    logic [7:0] cfg_pwr = 15, cfg_long = 2;
    mode_t      md = MODE_UNINIT;
    phase_t     ph = PH_IDLE;
    logic [3:0] istep = 0;
    logic       ack_ok = 1;
    logic [7:0] ticks = 0, dly = 0, bout = 0;
    logic       rs_q = 0;
    logic [3:0] snib = 0;
    logic       wact = 0, wpart = 0, need_cur = 0;
    logic [6:0] fidx = 0, pstart = 0, plen = 0, psent = 0;
    logic [7:0] screen[128];
    pin_result_t cur;

    function automatic logic [7:0] lcd_row_offset(input int r);
        case (r & 3)
            0: return 8'h00;
            1: return 8'h40;
            2: return 8'h14;
            default: return 8'h54;
        endcase
    endfunction

    task automatic drive_pins(input logic [3:0] n, input logic r, input logic e);
        cur.pw = 1; cur.nib = n; cur.rs = r; cur.en = e;
        ack_ok = 0;
    endtask

    task automatic begin_byte(input logic [7:0] b, input logic r);
        bout = b;
        rs_q = r;
        drive_pins(b[7:4], r, 1);
        ph = PH_HI_LOW;
    endtask

    // next byte of an active write
    task automatic advance_write();
        int dv, p, a, stp, tot, row, wi, nxt;
        dv = (cfg_cols != 0) ? cfg_cols : 1;
        if (!wact) begin
            md = MODE_IDLE;
        end else if (wpart) begin
            if (psent >= plen) begin
                wact = 0; md = MODE_IDLE;
            end else if (need_cur) begin
                p = pstart + psent;
                a = lcd_row_offset(p / dv) + p % dv;
                begin_byte(8'(8'h80 | a), 0);
                need_cur = 0;
            end else begin
                begin_byte(screen[psent], 1);
                psent = psent + 1;
                if (psent < plen) begin
                    nxt = pstart + psent;
                    if ((nxt - 1) / dv != nxt / dv) need_cur = 1;
                end else begin
                    wact = 0;
                end
            end
        end else begin
            stp = cfg_cols + 1;
            tot = cfg_rows * stp;
            if (tot > 127) tot = 127;
            if (fidx >= tot) begin
                wact = 0; md = MODE_IDLE;
            end else begin
                row = fidx / stp;
                wi = fidx % stp;
                if (wi == 0) begin_byte(8'h80 | lcd_row_offset(row), 0);
                else begin_byte(screen[row * cfg_cols + wi - 1], 1);
                fidx = fidx + 1;
                if (fidx >= tot) wact = 0;
            end
        end
    endtask

    task automatic handle_poll(input logic [7:0] el);
        int t;
        t = ticks + el;
        ticks = (t > 255) ? 8'd255 : 8'(t);
        if (!ack_ok) return;
        dly = (dly > el) ? dly - el : 8'd0;
        if (dly != 0) return;
        if (md == MODE_UNINIT) begin
            if (ticks >= cfg_pwr) begin
                md = MODE_INIT; istep = 0; ph = PH_IDLE;
            end
            return;
        end
        if (md == MODE_IDLE) return;
        case (ph)
            PH_IDLE: begin
                if (md == MODE_INIT) begin
                    if (istep <= 3) begin
                        snib = (istep < 3) ? NIB_WAKE : NIB_FOUR_BIT;
                        drive_pins(snib, 0, 1);
                        ph = PH_SINGLE_LOW;
                    end else if (istep <= 7) begin
                        case (istep)
                            4: begin_byte(8'h28, 0);
                            5: begin_byte(8'h0C, 0);
                            6: begin_byte(8'h01, 0);
                            default: begin_byte(8'h06, 0);
                        endcase
                    end else begin
                        md = MODE_IDLE;
                    end
                end else begin
                    advance_write();
                end
            end
            PH_HI_LOW: begin
                drive_pins(bout[7:4], rs_q, 0);
                ph = PH_LO_HIGH;
            end
            PH_LO_HIGH: begin
                drive_pins(bout[3:0], rs_q, 1);
                ph = PH_LO_LOW;
            end
            PH_LO_LOW: begin
                drive_pins(bout[3:0], rs_q, 0);
                ph = PH_IDLE;
                if (md == MODE_INIT) begin
                    dly = (bout == 8'h01 || bout == 8'h02) ? cfg_long : 8'd0;
                    istep = istep + 1;
                end else begin
                    dly = 0;
                end
            end
            PH_SINGLE_LOW: begin
                if (md == MODE_INIT) begin
                    drive_pins(snib, 0, 0);
                    dly = 0;
                    istep = istep + 1;
                end
                ph = PH_IDLE;
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    // expected pin result for one accepted transaction
    task automatic predict_pins(input lcd_req_t q, output pin_result_t r);
        int area;
        bit ok;
        cur = '{default: '0};
        case (q.kind)
            KIND_POLL: handle_poll(q.elapsed);
            KIND_ACK: ack_ok = 1;
            KIND_LOAD: screen[q.idx] = q.code;
            KIND_FULL, KIND_PARTIAL: begin
                area = cfg_rows * cfg_cols;
                ok = (md == MODE_IDLE) && !wact;
                if (ok && q.kind == KIND_PARTIAL &&
                    (q.pos >= area || q.len == 0 || q.pos + q.len > area)) ok = 0;
                if (ok) begin
                    if (q.kind == KIND_FULL) begin
                        fidx = 0; wpart = 0;
                    end else begin
                        pstart = q.pos; plen = q.len; psent = 0;
                        need_cur = 1; wpart = 1;
                    end
                    wact = 1; md = MODE_XFER; ph = PH_IDLE; dly = 0;
                    cur.status = STATUS_ACCEPTED;
                end else begin
                    cur.status = STATUS_REJECTED;
                end
            end
            KIND_ERROR: begin
                md = MODE_IDLE; ph = PH_IDLE; ack_ok = 0; wact = 0; wpart = 0;
            end
            default: ;
        endcase
        cur.rdy = (md == MODE_IDLE) && !wact;
        r = cur;
    endtask

    // random gap length, mostly short with a few long ones
    function automatic int pick_gap(input bit busy);
        int r;
        if (!busy) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input driver
    int  send_gap = 0;
    bit  send_busy = 1;
    always @(posedge aclk) begin
        lcd_req_t q;
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            if ($urandom_range(0, 199) == 0) send_busy = !send_busy;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 0;
            end else if (!hold_off && pending_reqs.size() > 0) begin
                q = pending_reqs.pop_front();
                s_kind <= q.kind;
                s_elapsed_ms <= q.elapsed;
                s_char_index <= q.idx;
                s_char_code <= q.code;
                s_position <= q.pos;
                s_length <= q.len;
                s_valid <= 1;
                send_gap = pick_gap(send_busy);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // result side backpressure
    int  recv_gap = 0;
    bit  recv_busy = 1;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) recv_busy = !recv_busy;
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                recv_gap = pick_gap(recv_busy);
            end
        end
    end

    // prediction on input transaction, comparison on result transaction
    always @(posedge aclk) begin
        lcd_req_t q;
        pin_result_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                q = '{s_kind, s_elapsed_ms, s_char_index, s_char_code, s_position, s_length};
                predict_pins(q, e);
                expected_pins.push_back(e);
            end
            if (m_valid && m_ready) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    failed = 1;
                end else begin
                    e = expected_pins.pop_front();
                    if (m_pin_write !== e.pw || m_pin_nibble !== e.nib || m_pin_rs !== e.rs ||
                        m_pin_enable !== e.en || m_request_status !== e.status ||
                        m_ready_res !== e.rdy) begin
                        $display("%0t: expected pw=%0d nib=%h rs=%0d en=%0d st=%0d rdy=%0d",
                                 $time, e.pw, e.nib, e.rs, e.en, e.status, e.rdy);
                        $display("%0t: actual   pw=%0d nib=%h rs=%0d en=%0d st=%0d rdy=%0d",
                                 $time, m_pin_write, m_pin_nibble, m_pin_rs, m_pin_enable,
                                 m_request_status, m_ready_res);
                        failed = 1;
                    end
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (addr)
            REG_ROW_COUNT: cfg_rows = data[2:0];
            REG_COL_COUNT: cfg_cols = data[4:0];
            REG_POWER_DELAY: cfg_pwr = data[7:0];
            default: cfg_long = data[7:0];
        endcase
    endtask

    task automatic push_req(input logic [2:0] k, input logic [7:0] el, input logic [6:0] ix,
                            input logic [7:0] cd, input logic [6:0] ps, input logic [6:0] ln);
        lcd_req_t q;
        q = '{k, el, ix, cd, ps, ln};
        pending_reqs.push_back(q);
    endtask

    // mostly poll and ack pairs so that writes get all the way through
    task automatic queue_random(input int n);
        int r, area, p;
        area = cfg_rows * cfg_cols;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 58) begin
                push_req(KIND_POLL, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                         : $urandom_range(0, 255), $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 9) != 0)
                    push_req(KIND_ACK, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 66) begin
                push_req(KIND_LOAD, $urandom, $urandom_range(0, 127), $urandom, $urandom,
                         $urandom);
            end else if (r < 73) begin
                push_req(KIND_FULL, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 84) begin
                if ($urandom_range(0, 4) != 0) begin
                    p = $urandom_range(0, area - 1);
                    push_req(KIND_PARTIAL, $urandom, $urandom, $urandom, p,
                             $urandom_range(1, area - p));
                end else begin
                    push_req(KIND_PARTIAL, $urandom, $urandom, $urandom, $urandom_range(0, 127),
                             $urandom_range(0, 127));
                end
            end else if (r < 86) begin
                push_req(KIND_ERROR, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 88) begin
                push_req($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                push_req(KIND_POLL, $urandom_range(0, 255), $urandom, $urandom, $urandom,
                         $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_pins.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // run phases with different display geometries and delays
    initial begin
        int rows_set[5] = '{4, 1, 4, 2, 3};
        int cols_set[5] = '{20, 1, 20, 16, 7};
        while (!aresetn) @(posedge aclk);
        reg_write(REG_ROW_COUNT, 4);
        reg_write(REG_COL_COUNT, 20);
        reg_write(REG_POWER_DELAY, 255);
        reg_write(REG_LONG_DELAY, 255);
        // fill the visible screen so no cell is read before it is written
        for (int i = 0; i < 80; i++) push_req(KIND_LOAD, 0, i, $urandom, 0, 0);
        // directed: requests before init, power-on wait, extreme fields
        push_req(KIND_FULL, 0, 0, 0, 0, 0);
        push_req(KIND_PARTIAL, 0, 0, 0, 0, 1);
        push_req(KIND_LOAD, 8'hFF, 7'h7F, 8'hFF, 7'h7F, 7'h7F);
        push_req(3'd6, 8'hFF, 7'h7F, 8'hFF, 7'h7F, 7'h7F);
        push_req(3'd7, 0, 0, 0, 0, 0);
        push_req(KIND_POLL, 200, 0, 0, 0, 0);
        push_req(KIND_POLL, 255, 0, 0, 0, 0);
        for (int i = 0; i < 20; i++) begin
            push_req(KIND_POLL, (i % 5 == 0) ? 8'd255 : 8'd0, 0, 0, 0, 0);
            if (i != 7) push_req(KIND_ACK, 0, 0, 0, 0, 0);
        end
        push_req(KIND_PARTIAL, 0, 0, 0, 79, 1);
        push_req(KIND_PARTIAL, 0, 0, 0, 80, 1);
        push_req(KIND_PARTIAL, 0, 0, 0, 0, 0);
        push_req(KIND_PARTIAL, 0, 0, 0, 5, 80);
        push_req(KIND_ERROR, 0, 0, 0, 0, 0);
        push_req(KIND_POLL, 1, 0, 0, 0, 0);
        push_req(KIND_ACK, 0, 0, 0, 0, 0);
        hold_off <= 0;
        queue_random(150);
        for (int ph_i = 0; ph_i < 6; ph_i++) begin
            // let every queued transaction and its result finish first
            wait_drained();
            hold_off <= 1;
            if (ph_i < 5) begin
                reg_write(REG_ROW_COUNT, rows_set[ph_i]);
                reg_write(REG_COL_COUNT, cols_set[ph_i]);
            end else begin
                reg_write(REG_ROW_COUNT, $urandom_range(1, 4));
                reg_write(REG_COL_COUNT, $urandom_range(1, 20));
            end
            reg_write(REG_POWER_DELAY, (ph_i == 1) ? 0 : $urandom_range(0, 255));
            reg_write(REG_LONG_DELAY, (ph_i == 1) ? 0 : $urandom_range(0, 255));
            queue_random(150);
            hold_off <= 0;
        end
        @(posedge aclk);
        wait_drained();
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* char_lcd_nibble_sequencer_core.f */
design/clns_pkg.sv
design/clns_divider.sv
design/clns_screen_ram.sv
design/char_lcd_nibble_sequencer_core.sv
dv/char_lcd_nibble_sequencer_core_tb.sv
